@@ rtl/bslscan_pkg.sv @@
// ----------------------------------------------------------------------------
// bslscan_pkg
// Shared types and constants of the status line scanner: message depth,
// keyword tables, register indexes and the result bundle.
// ----------------------------------------------------------------------------
package bslscan_pkg;

  localparam int unsigned MessageDepth = 256;
  localparam int unsigned CountW       = $clog2(MessageDepth);

  localparam int unsigned ByteW = 8;
  localparam int unsigned ProgW = 4;

  localparam logic [ProgW-1:0] OpenLen  = 4'd11;
  localparam logic [ProgW-1:0] CloseLen = 4'd10;

  // Keyword tables, padded to the full progress range with zero bytes.
  localparam logic [ByteW-1:0] OpenWord [16] = '{
    8'h53, 8'h54, 8'h52, 8'h45, 8'h41, 8'h4D, 8'h5F, 8'h4F,
    8'h50, 8'h45, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [ByteW-1:0] CloseWord [16] = '{
    8'h44, 8'h49, 8'h53, 8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45,
    8'h43, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [ByteW-1:0] StatusTermReset = 8'h25;  // percent sign
  localparam logic [ByteW-1:0] LineTermReset   = 8'h0A;  // line feed

  typedef enum logic {
    CfgStatusTerm = 1'b0,
    CfgLineTerm   = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_position;
    logic             line_end;
    logic             status_end;
    logic             link_up;
    logic             link_changed;
  } result_t;

endpackage

@@ rtl/ble_status_line_scanner_top.sv @@
// ----------------------------------------------------------------------------
// ble_status_line_scanner_top
// Frames received serial bytes into messages, scans status messages for the
// link keywords and echoes every byte with its position and end flags.
// ----------------------------------------------------------------------------
// Output: each result is registered in the output register, or first in the skid register while the output is stalled.
// Throughput: one byte per cycle while the skid register is empty; the keyword
//   matchers and the message counter update in the cycle a byte is accepted,
//   and a two-entry buffer (output plus skid register) parks one stalled byte.
// Reset: asynchronous, active low; clears counter, matchers, link flag and
//   buffer valid bits, and loads the terminators with percent and line feed.
module ble_status_line_scanner_top
  import bslscan_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [ByteW-1:0] cfg_data_i,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] rx_byte_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] data_byte_o,
  output logic [ByteW-1:0] byte_position_o,
  output logic             line_end_o,
  output logic             status_end_o,
  output logic             link_up_o,
  output logic             link_changed_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ByteW-1:0] status_term_q;
  logic [ByteW-1:0] line_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_term_q <= StatusTermReset;
      line_term_q   <= LineTermReset;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgStatusTerm: status_term_q <= cfg_data_i;
        CfgLineTerm:   line_term_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the skid register is the only thing that blocks intake
  // --------------------------------------------------------------------------
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    in_fire, out_fire;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  // --------------------------------------------------------------------------
  // Message state
  // --------------------------------------------------------------------------
  logic [CountW-1:0] count_q, count_d;
  logic [ProgW-1:0]  open_prog_q, open_prog_d;
  logic [ProgW-1:0]  close_prog_q, close_prog_d;
  logic              open_found_q, open_found_d;
  logic              close_found_q, close_found_d;
  logic              zero_seen_q, zero_seen_d;
  logic              link_q, link_d;
  result_t           res;

  logic [CountW+ByteW-1:0] pos_ext;
  logic [ProgW-1:0]        open_adv, close_adv;
  logic                    restart;

  assign pos_ext = {{ByteW{1'b0}}, count_q};

  always_comb begin
    // Step both matchers; each keyword's first letter appears only once,
    // so a mismatch falls back to a one or zero length prefix.
    if (open_prog_q < OpenLen && OpenWord[open_prog_q] == rx_byte_i) begin
      open_adv = open_prog_q + 1'b1;
    end else begin
      open_adv = (OpenWord[0] == rx_byte_i) ? 4'd1 : 4'd0;
    end
    if (close_prog_q < CloseLen && CloseWord[close_prog_q] == rx_byte_i) begin
      close_adv = close_prog_q + 1'b1;
    end else begin
      close_adv = (CloseWord[0] == rx_byte_i) ? 4'd1 : 4'd0;
    end

    zero_seen_d   = zero_seen_q || (rx_byte_i == '0);
    open_prog_d   = open_prog_q;
    close_prog_d  = close_prog_q;
    open_found_d  = open_found_q;
    close_found_d = close_found_q;

    // Scan only text before the first zero byte
    if (!zero_seen_d) begin
      if (open_adv == OpenLen) begin
        open_found_d = 1'b1;
        open_prog_d  = '0;
      end else begin
        open_prog_d = open_adv;
      end
      if (close_adv == CloseLen) begin
        close_found_d = 1'b1;
        close_prog_d  = '0;
      end else begin
        close_prog_d = close_adv;
      end
    end

    link_d  = link_q;
    restart = 1'b0;
    count_d = count_q + 1'b1;

    res               = '0;
    res.data_byte     = rx_byte_i;
    res.byte_position = pos_ext[ByteW-1:0];

    // Status terminator wins when both terminators are equal
    if (rx_byte_i == status_term_q) begin
      res.status_end = 1'b1;
      restart        = 1'b1;
      if (open_found_d) begin
        link_d           = 1'b1;
        res.link_changed = 1'b1;
      end else if (close_found_d) begin
        link_d           = 1'b0;
        res.link_changed = 1'b1;
      end
    end else if (rx_byte_i == line_term_q) begin
      res.line_end = 1'b1;
      restart      = 1'b1;
    end else if (count_q == CountW'(MessageDepth - 1)) begin
      // Full message without terminator: drop it and start over
      restart = 1'b1;
    end
    res.link_up = link_d;

    if (restart) begin
      count_d       = '0;
      open_prog_d   = '0;
      close_prog_d  = '0;
      open_found_d  = 1'b0;
      close_found_d = 1'b0;
      zero_seen_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      open_prog_q   <= '0;
      close_prog_q  <= '0;
      open_found_q  <= 1'b0;
      close_found_q <= 1'b0;
      zero_seen_q   <= 1'b0;
      link_q        <= 1'b0;
    end else if (in_fire) begin
      count_q       <= count_d;
      open_prog_q   <= open_prog_d;
      close_prog_q  <= close_prog_d;
      open_found_q  <= open_found_d;
      close_found_q <= close_found_d;
      zero_seen_q   <= zero_seen_d;
      link_q        <= link_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      // Output slot frees up: refill from skid first, else from a new item
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      // Output held by stall: park the new item
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_byte_o     = out_q.data_byte;
  assign byte_position_o = out_q.byte_position;
  assign line_end_o      = out_q.line_end;
  assign status_end_o    = out_q.status_end;
  assign link_up_o       = out_q.link_up;
  assign link_changed_o  = out_q.link_changed;

endmodule

@@ rtl/bslscan_checker.sv @@
// ----------------------------------------------------------------------------
// bslscan_checker
// Port-level checks of the status line scanner, bound to the top level.
// ----------------------------------------------------------------------------
module bslscan_checker
  import bslscan_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [ByteW-1:0] data_byte_o,
  input logic             line_end_o,
  input logic             status_end_o,
  input logic             link_up_o,
  input logic             link_changed_o
);

  // A status change is only reported on the byte that closes a status message
  a_change_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && link_changed_o |-> status_end_o)
    else $error("link change without status end");

  // One byte never ends both kinds of message
  a_single_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(line_end_o && status_end_o))
    else $error("line end and status end together");

  // Intake only stalls while a result is waiting on the output
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A stalled result stays on the output
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(link_up_o))
    else $error("stalled result changed");

endmodule

bind ble_status_line_scanner_top bslscan_checker u_bslscan_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .data_byte_o    (data_byte_o),
  .line_end_o     (line_end_o),
  .status_end_o   (status_end_o),
  .link_up_o      (link_up_o),
  .link_changed_o (link_changed_o)
);
